// ===== src/key_autorepeat_value_adjuster_unit_assert.svh =====
// Assertion macros shared by the checker of the value adjuster.
`ifndef KEY_AUTOREPEAT_VALUE_ADJUSTER_UNIT_ASSERT_SVH
`define KEY_AUTOREPEAT_VALUE_ADJUSTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define KAVU_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kavu assertion failed");

// Next-cycle implication, disabled while reset is low.
`define KAVU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kavu assertion failed");

`endif

// ===== src/kavu_pkg.sv =====
`timescale 1ns / 1ps

package kavu_pkg;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned KEY_W       = 3;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CNT_W-1:0] DELAY_RESET  = 8'd30;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 8'd5;
  localparam logic [CNT_W-1:0] HOLD_MAX     = 8'd255;
  localparam logic [CNT_W-1:0] HOLD_STEP75  = 8'd200;
  localparam logic [CNT_W-1:0] HOLD_STEP25  = 8'd150;
  localparam logic [CNT_W-1:0] HOLD_STEP10  = 8'd100;

  localparam logic [STEP_W-1:0] STEP_1  = 7'd1;
  localparam logic [STEP_W-1:0] STEP_10 = 7'd10;
  localparam logic [STEP_W-1:0] STEP_25 = 7'd25;
  localparam logic [STEP_W-1:0] STEP_75 = 7'd75;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE       = 3'd0,
    KEY_PRESS_UP   = 3'd1,
    KEY_PRESS_DOWN = 3'd2,
    KEY_PRESS_FWD  = 3'd3,
    KEY_PRESS_BACK = 3'd4,
    KEY_HOLD_UP    = 3'd5,
    KEY_HOLD_DOWN  = 3'd6
  } key_e;

  typedef enum logic [1:0] {
    ST_EDITING   = 2'd0,
    ST_ACCEPTED  = 2'd1,
    ST_DISCARDED = 2'd2
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REPEAT_DELAY  = 1'b0,
    CFG_REPEAT_PERIOD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                       operation;
    key_e                      key_event;
    logic signed [FIELD_W-1:0] start_value;
    logic signed [FIELD_W-1:0] min_value;
    logic signed [FIELD_W-1:0] max_value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] delay_count;
    logic [CNT_W-1:0] period_count;
    logic [CNT_W-1:0] hold_ticks;
  } counters_t;

  typedef struct packed {
    logic              up;
    logic              down;
    logic              fwd;
    logic              back;
    logic [STEP_W-1:0] step;
  } move_t;

  typedef struct packed {
    logic [STEP_W-1:0]         step_applied;
    logic signed [FIELD_W-1:0] accepted_value;
    status_e                   edit_status;
    logic signed [FIELD_W-1:0] current_value;
  } result_t;

endpackage

// ===== src/key_autorepeat_value_adjuster_unit.sv =====
`timescale 1ns / 1ps

// Key auto-repeat value adjuster. Each item is one key tick or a load of the
// starting value; each gives exactly one result item in the same order. The
// block takes one item per clock while the result side is not stalled; each
// item passes from the input register through the combinational update of the
// edit value and the delay, period and hold counters into the result register.
// A result waiting on the master side holds the input register, so a new item
// can enter only while that register is empty. Configuration writes (repeat
// delay, index 0, and repeat period, index 1) take effect at once and belong
// to idle periods. The stored value is VALUE_WIDTH bits; results are shown in
// 16 bits two's complement.
module key_autorepeat_value_adjuster_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_event[2:0], start_value[18:3], min_value[34:19], max_value[50:35], zero fill
  input  logic [kavu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // operation[0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // current_value[15:0], edit_status[17:16], accepted_value[33:18],
  // step_applied[40:34], zero fill
  output logic [kavu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [kavu_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [kavu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import kavu_pkg::*;

  logic                          in_valid_q;
  item_t                         item_d;
  item_t                         item_q;
  logic                          out_valid_q;
  result_t                       result_d;
  result_t                       result_q;
  logic                          advance;
  logic signed [VALUE_WIDTH-1:0] edit_d;
  logic signed [VALUE_WIDTH-1:0] edit_q;
  counters_t                     counters_d;
  counters_t                     counters_q;
  move_t                         move;
  logic [CNT_W-1:0]              repeat_delay_q;
  logic [CNT_W-1:0]              repeat_period_q;

  // advance the input stage whenever the result register is free or emptying
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(result_q);

  assign item_d.operation   = op_e'(s_axis_tuser);
  assign item_d.key_event   = key_e'(s_axis_tdata[2:0]);
  assign item_d.start_value = s_axis_tdata[18:3];
  assign item_d.min_value   = s_axis_tdata[34:19];
  assign item_d.max_value   = s_axis_tdata[50:35];

  kavu_repeat u_repeat (
    .operation_i     (item_q.operation),
    .key_event_i     (item_q.key_event),
    .counters_q_i    (counters_q),
    .repeat_delay_i  (repeat_delay_q),
    .repeat_period_i (repeat_period_q),
    .counters_d_o    (counters_d),
    .move_o          (move)
  );

  kavu_clamp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_clamp (
    .item_i   (item_q),
    .move_i   (move),
    .edit_q_i (edit_q),
    .edit_d_o (edit_d),
    .result_o (result_d)
  );

  // control, state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      edit_q          <= '0;
      counters_q      <= '0;
      repeat_delay_q  <= DELAY_RESET;
      repeat_period_q <= PERIOD_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (!out_valid_q || m_axis_tready) begin
        out_valid_q <= in_valid_q;
      end
      // commit the state only as the item moves into the result register
      if (advance) begin
        edit_q     <= edit_d;
        counters_q <= counters_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_wdata_i;
          CFG_REPEAT_PERIOD: repeat_period_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

endmodule

// ===== src/kavu_repeat.sv =====
`timescale 1ns / 1ps

module kavu_repeat (
  input  kavu_pkg::op_e                    operation_i,
  input  kavu_pkg::key_e                   key_event_i,
  input  kavu_pkg::counters_t              counters_q_i,
  input  logic [kavu_pkg::CNT_W-1:0]       repeat_delay_i,
  input  logic [kavu_pkg::CNT_W-1:0]       repeat_period_i,
  output kavu_pkg::counters_t              counters_d_o,
  output kavu_pkg::move_t                  move_o
);
  import kavu_pkg::*;

  logic             fire;
  logic [CNT_W-1:0] period_inc;
  logic [CNT_W-1:0] hold_inc;

  assign period_inc = counters_q_i.period_count + CNT_W'(1);
  assign hold_inc   = (counters_q_i.hold_ticks == HOLD_MAX) ? HOLD_MAX
                                                            : counters_q_i.hold_ticks + CNT_W'(1);

  always_comb begin
    counters_d_o = counters_q_i;
    move_o       = '0;
    fire         = 1'b0;
    if (operation_i == OP_KEY) begin
      unique case (key_event_i)
        KEY_PRESS_UP, KEY_PRESS_DOWN, KEY_PRESS_FWD, KEY_PRESS_BACK: begin
          counters_d_o.delay_count = '0;
          counters_d_o.hold_ticks  = '0;
          move_o.up   = (key_event_i == KEY_PRESS_UP);
          move_o.down = (key_event_i == KEY_PRESS_DOWN);
          move_o.fwd  = (key_event_i == KEY_PRESS_FWD);
          move_o.back = (key_event_i == KEY_PRESS_BACK);
        end
        KEY_HOLD_UP, KEY_HOLD_DOWN: begin
          // wait out the delay, then fire once per period
          if (counters_q_i.delay_count < repeat_delay_i) begin
            counters_d_o.delay_count  = counters_q_i.delay_count + CNT_W'(1);
            counters_d_o.period_count = '0;
          end else begin
            counters_d_o.period_count = period_inc;
            if (period_inc >= repeat_period_i) begin
              counters_d_o.period_count = '0;
              fire = 1'b1;
            end
          end
          counters_d_o.hold_ticks = hold_inc;
          move_o.up   = fire && (key_event_i == KEY_HOLD_UP);
          move_o.down = fire && (key_event_i == KEY_HOLD_DOWN);
        end
        default: begin
          counters_d_o.delay_count = '0;
          counters_d_o.hold_ticks  = '0;
        end
      endcase

      // accelerate with hold time; pull the count back to the top step
      if (counters_d_o.hold_ticks >= HOLD_STEP75) begin
        move_o.step             = STEP_75;
        counters_d_o.hold_ticks = HOLD_STEP75;
      end else if (counters_d_o.hold_ticks >= HOLD_STEP25) begin
        move_o.step = STEP_25;
      end else if (counters_d_o.hold_ticks >= HOLD_STEP10) begin
        move_o.step = STEP_10;
      end else begin
        move_o.step = STEP_1;
      end
    end
  end

endmodule

// ===== src/kavu_clamp.sv =====
`timescale 1ns / 1ps

module kavu_clamp #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  kavu_pkg::item_t                 item_i,
  input  kavu_pkg::move_t                 move_i,
  input  logic signed [VALUE_WIDTH-1:0]   edit_q_i,
  output logic signed [VALUE_WIDTH-1:0]   edit_d_o,
  output kavu_pkg::result_t               result_o
);
  import kavu_pkg::*;

  localparam int unsigned EXT_W = ((VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W) + 2;
  localparam logic signed [EXT_W-1:0] RANGE_HI =
    EXT_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] RANGE_LO = -RANGE_HI - EXT_W'(1);

  logic signed [EXT_W-1:0] edit_ext;
  logic signed [EXT_W-1:0] step_ext;
  logic signed [EXT_W-1:0] start_ext;
  logic signed [EXT_W-1:0] lo_ext;
  logic signed [EXT_W-1:0] hi_ext;
  logic signed [EXT_W-1:0] sum_up;
  logic signed [EXT_W-1:0] sum_dn;
  logic signed [EXT_W-1:0] next_ext;
  logic signed [EXT_W-1:0] sat_ext;

  assign edit_ext  = EXT_W'(edit_q_i);
  assign step_ext  = EXT_W'($unsigned(move_i.step));
  assign start_ext = EXT_W'(item_i.start_value);
  assign lo_ext    = EXT_W'(item_i.min_value);
  assign hi_ext    = EXT_W'(item_i.max_value);
  assign sum_up    = edit_ext + step_ext;
  assign sum_dn    = edit_ext - step_ext;

  always_comb begin
    next_ext                = edit_ext;
    result_o.edit_status    = ST_EDITING;
    result_o.accepted_value = '0;
    result_o.step_applied   = '0;
    if (item_i.operation == OP_LOAD) begin
      next_ext = start_ext;
    end else if (move_i.up) begin
      next_ext              = (sum_up > hi_ext) ? hi_ext : sum_up;
      result_o.step_applied = move_i.step;
    end else if (move_i.down) begin
      next_ext              = (sum_dn < lo_ext) ? lo_ext : sum_dn;
      result_o.step_applied = move_i.step;
    end else if (move_i.fwd) begin
      result_o.edit_status    = ST_ACCEPTED;
      result_o.accepted_value = edit_ext[FIELD_W-1:0];
    end else if (move_i.back) begin
      result_o.edit_status = ST_DISCARDED;
    end

    // saturate to the range of the stored value
    if (next_ext > RANGE_HI) begin
      sat_ext = RANGE_HI;
    end else if (next_ext < RANGE_LO) begin
      sat_ext = RANGE_LO;
    end else begin
      sat_ext = next_ext;
    end
    result_o.current_value = sat_ext[FIELD_W-1:0];
  end

  assign edit_d_o = sat_ext[VALUE_WIDTH-1:0];

endmodule

// ===== src/kavu_checker.sv =====
`timescale 1ns / 1ps

`include "key_autorepeat_value_adjuster_unit_assert.svh"

module kavu_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [kavu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input logic                                 s_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [kavu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                 cfg_we_i,
  input logic [kavu_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input logic [kavu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import kavu_pkg::*;

  logic [1:0]        status;
  logic [15:0]       accepted;
  logic [STEP_W-1:0] step;
  logic              unused_in;

  assign status   = m_axis_tdata[17:16];
  assign accepted = m_axis_tdata[33:18];
  assign step     = m_axis_tdata[40:34];
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata)
                   ^ cfg_we_i ^ (^cfg_index_i) ^ (^cfg_wdata_i);

  // a stalled result holds
  `KAVU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // a committed value is reported only with the accepted status
  `KAVU_ASSERT_NOW(a_accepted_zero, clk_i, rst_ni,
    m_axis_tvalid && (status != ST_ACCEPTED), accepted == 16'd0)

  // the step is one of the acceleration levels, or none
  `KAVU_ASSERT_NOW(a_step_level, clk_i, rst_ni, m_axis_tvalid,
    (step == '0) || (step == STEP_1) || (step == STEP_10) || (step == STEP_25) ||
    (step == STEP_75))

  // a move never comes with a commit or a discard
  `KAVU_ASSERT_NOW(a_step_editing, clk_i, rst_ni, m_axis_tvalid && (step != '0),
    (status == ST_EDITING) && !(unused_in && 1'b0))

endmodule

bind key_autorepeat_value_adjuster_unit kavu_checker u_kavu_checker (.*);

// ===== verif/kavu_edit_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels and the register port, predicts each edit
// result and compares it with what leaves the block.
module kavu_edit_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // key_event[2:0], start_value[18:3], min_value[34:19], max_value[50:35], zero fill
  input  logic [kavu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // operation[0]
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // current_value[15:0], edit_status[17:16], accepted_value[33:18],
  // step_applied[40:34], zero fill
  input  logic [kavu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [kavu_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [kavu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output int                                mismatch_count_o,
  output int                                results_due_o
);

  import kavu_pkg::*;

  localparam int VALUE_HI = 32767;
  localparam int VALUE_LO = -32768;

  // Shadow of the editor state and its two registers.
  logic signed [FIELD_W-1:0] edit_value_q;
  logic [CNT_W-1:0]          delay_q;
  logic [CNT_W-1:0]          period_q;
  logic [CNT_W-1:0]          hold_q;
  logic [CNT_W-1:0]          repeat_delay_q;
  logic [CNT_W-1:0]          repeat_period_q;

  result_t edit_results_due[$];
  result_t seen;
  result_t wanted;

  function automatic logic signed [FIELD_W-1:0] clip_to_value(input int v);
    if (v > VALUE_HI) return VALUE_HI[FIELD_W-1:0];
    if (v < VALUE_LO) return VALUE_LO[FIELD_W-1:0];
    return v[FIELD_W-1:0];
  endfunction

  // One tick of a held key: count out the delay, then fire once per period.
  function automatic logic held_key_fires();
    logic fire;
    fire = 1'b0;
    if (delay_q < repeat_delay_q) begin
      delay_q  = delay_q + 1'b1;
      period_q = '0;
    end else begin
      period_q = period_q + 1'b1;
      if (period_q >= repeat_period_q) begin
        period_q = '0;
        fire     = 1'b1;
      end
    end
    if (hold_q != HOLD_MAX) hold_q = hold_q + 1'b1;
    return fire;
  endfunction

  function automatic result_t next_edit_result(input logic op,
                                               input logic [KEY_W-1:0] key,
                                               input logic signed [FIELD_W-1:0] start,
                                               input logic signed [FIELD_W-1:0] lo,
                                               input logic signed [FIELD_W-1:0] hi);
    result_t           r;
    logic              up;
    logic              down;
    logic              fwd;
    logic              back;
    logic [STEP_W-1:0] step;
    int                v;
    r    = '0;
    up   = 1'b0;
    down = 1'b0;
    fwd  = 1'b0;
    back = 1'b0;
    r.edit_status = ST_EDITING;
    if (op == OP_LOAD) begin
      edit_value_q = start;
    end else begin
      case (key)
        KEY_PRESS_UP:   up = 1'b1;
        KEY_PRESS_DOWN: down = 1'b1;
        KEY_PRESS_FWD:  fwd = 1'b1;
        KEY_PRESS_BACK: back = 1'b1;
        KEY_HOLD_UP:    up = held_key_fires();
        KEY_HOLD_DOWN:  down = held_key_fires();
        default: ;
      endcase
      // Anything but a held key restarts the delay and hold counts.
      if (key != KEY_HOLD_UP && key != KEY_HOLD_DOWN) begin
        delay_q = '0;
        hold_q  = '0;
      end
      if (hold_q >= HOLD_STEP75) begin
        step   = STEP_75;
        hold_q = HOLD_STEP75;
      end else if (hold_q >= HOLD_STEP25) begin
        step = STEP_25;
      end else if (hold_q >= HOLD_STEP10) begin
        step = STEP_10;
      end else begin
        step = STEP_1;
      end
      if (up) begin
        v = int'(edit_value_q) + int'(step);
        if (v > int'(hi)) v = int'(hi);
        edit_value_q   = clip_to_value(v);
        r.step_applied = step;
      end else if (down) begin
        v = int'(edit_value_q) - int'(step);
        if (v < int'(lo)) v = int'(lo);
        edit_value_q   = clip_to_value(v);
        r.step_applied = step;
      end else if (fwd) begin
        r.edit_status    = ST_ACCEPTED;
        r.accepted_value = edit_value_q;
      end else if (back) begin
        r.edit_status = ST_DISCARDED;
      end
    end
    r.current_value = edit_value_q;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_value_q     = '0;
      delay_q          = '0;
      period_q         = '0;
      hold_q           = '0;
      repeat_delay_q   = DELAY_RESET;
      repeat_period_q  = PERIOD_RESET;
      mismatch_count_o = 0;
      edit_results_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REPEAT_DELAY:  repeat_delay_q = cfg_wdata_i;
          CFG_REPEAT_PERIOD: repeat_period_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (edit_results_due.size() == 0) begin
          report_mismatch("unexpected result, current_value", int'(seen.current_value), 0);
        end else begin
          wanted = edit_results_due.pop_front();
          if (seen.current_value != wanted.current_value)
            report_mismatch("current_value", int'(seen.current_value),
                            int'(wanted.current_value));
          if (seen.edit_status != wanted.edit_status)
            report_mismatch("edit_status", int'(seen.edit_status), int'(wanted.edit_status));
          if (seen.accepted_value != wanted.accepted_value)
            report_mismatch("accepted_value", int'(seen.accepted_value),
                            int'(wanted.accepted_value));
          if (seen.step_applied != wanted.step_applied)
            report_mismatch("step_applied", int'(seen.step_applied),
                            int'(wanted.step_applied));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        edit_results_due.push_back(next_edit_result(s_axis_tuser,
                                                    s_axis_tdata[2:0],
                                                    s_axis_tdata[18:3],
                                                    s_axis_tdata[34:19],
                                                    s_axis_tdata[50:35]));
      end
    end
    results_due_o = edit_results_due.size();
  end

endmodule

// ===== verif/tb_key_autorepeat_value_adjuster_unit.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the key auto-repeat value adjuster. The checker
// beside the block does all prediction and comparison; this module only
// makes key ticks and loads, shapes the idling on both channels, writes the
// two repeat registers between phases and calls the result.
module tb_key_autorepeat_value_adjuster_unit;

  import kavu_pkg::*;

  localparam int HALF_PERIOD_NS = 5;
  localparam int RESET_CYCLES   = 9;
  // Settling margin after the last predicted result is back.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles without any item moving before the run is declared hung.
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 310;

  localparam logic [KEY_W-1:0]         KEY_UNUSED = 3'd7;
  localparam logic signed [FIELD_W-1:0] VALUE_MIN = 16'sh8000;
  localparam logic signed [FIELD_W-1:0] VALUE_MAX = 16'sh7FFF;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // key_event[2:0], start_value[18:3], min_value[34:19], max_value[50:35], zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // operation[0]
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // current_value[15:0], edit_status[17:16], accepted_value[33:18],
  // step_applied[40:34], zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  int mismatches;
  int results_due;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles;
  int items_sent;

  key_autorepeat_value_adjuster_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  kavu_edit_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD_NS) clk_i = ~clk_i;
  end

  // Receiver: stall at random in the share the current phase asks for.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hang detector: restart the count whenever an item or a register write
  // moves, give up once nothing has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Offer one item, idling first at random, and hold it until it is taken.
  // Called and left at a falling edge; tvalid is only lowered in a gap, so
  // back-to-back items keep it high without a glitch.
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic signed [FIELD_W-1:0] start,
                           input logic signed [FIELD_W-1:0] lo,
                           input logic signed [FIELD_W-1:0] hi);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, hi, lo, start, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending, let every predicted result come back, then let the
  // pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Drain, then write both repeat registers back to back.
  task automatic set_repeat(input int delay_ticks, input int period_ticks);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_REPEAT_DELAY;
    cfg_wdata_i <= delay_ticks[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_index_i <= CFG_REPEAT_PERIOD;
    cfg_wdata_i <= period_ticks[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Values lean towards the range ends and zero, with full random mixed in.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    int v;
    case ($urandom_range(3))
      0:       v = 32767 - int'($urandom_range(120));
      1:       v = -32768 + int'($urandom_range(120));
      2:       v = int'($urandom_range(600)) - 300;
      default: v = int'($urandom);
    endcase
    return v[FIELD_W-1:0];
  endfunction

  task automatic pick_bounds(output logic signed [FIELD_W-1:0] lo,
                             output logic signed [FIELD_W-1:0] hi);
    int a;
    int b;
    a = $urandom_range(2000);
    b = $urandom_range(2000);
    case ($urandom_range(3))
      0: begin
        lo = VALUE_MIN;
        hi = VALUE_MAX;
      end
      1: begin
        // Either order, so crossed bounds turn up too.
        lo = pick_value();
        hi = pick_value();
      end
      default: begin
        lo = FIELD_W'(-a);
        hi = FIELD_W'(b);
      end
    endcase
  endtask

  // Mostly well-formed edits: optional load, a press, a run of holds and a
  // closing key. The rest is stray keys, loads and holds with no press.
  task automatic run_random(input int count);
    int                       stop_at;
    int                       hold_len;
    logic                     go_up;
    logic [KEY_W-1:0]         hold_key;
    logic [KEY_W-1:0]         any_key;
    logic signed [FIELD_W-1:0] lo;
    logic signed [FIELD_W-1:0] hi;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick_bounds(lo, hi);
      any_key = KEY_W'($urandom_range(7));
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          if ($urandom_range(1)) send_item(OP_LOAD, any_key, pick_value(), lo, hi);
          go_up = ($urandom_range(1) != 0);
          send_item(OP_KEY, go_up ? KEY_PRESS_UP : KEY_PRESS_DOWN, pick_value(), lo, hi);
          hold_key = go_up ? KEY_HOLD_UP : KEY_HOLD_DOWN;
          // Some runs go past every step threshold and the hold ceiling.
          hold_len = ($urandom_range(9) < 3) ? $urandom_range(270, 150) : $urandom_range(40);
          repeat (hold_len) begin
            // Now and then swap direction mid-run; the counts carry on.
            if ($urandom_range(49) == 0) hold_key = go_up ? KEY_HOLD_DOWN : KEY_HOLD_UP;
            send_item(OP_KEY, hold_key, pick_value(), lo, hi);
          end
          case ($urandom_range(2))
            0:       send_item(OP_KEY, KEY_PRESS_FWD, pick_value(), lo, hi);
            1:       send_item(OP_KEY, KEY_PRESS_BACK, pick_value(), lo, hi);
            default: send_item(OP_KEY, KEY_NONE, pick_value(), lo, hi);
          endcase
        end
        11, 12, 13, 14, 15: send_item(OP_KEY, any_key, pick_value(), lo, hi);
        16, 17:             send_item(OP_LOAD, any_key, pick_value(), lo, hi);
        default: begin
          repeat ($urandom_range(8, 1))
            send_item(OP_KEY, $urandom_range(1) ? KEY_HOLD_UP : KEY_HOLD_DOWN,
                      pick_value(), lo, hi);
        end
      endcase
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_REPEAT_DELAY;
    cfg_wdata_i   = '0;
    tx_idle_pct   = 32;
    rx_idle_pct   = 60;
    stall_cycles  = 0;
    items_sent    = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed edits under the reset repeat settings.
    // Load the top of the range; the key field of a load is ignored.
    send_item(OP_LOAD, KEY_HOLD_UP, VALUE_MAX, VALUE_MIN, VALUE_MAX);
    send_item(OP_KEY, KEY_PRESS_UP, '0, VALUE_MIN, VALUE_MAX);
    // Bottom of the range, then step down against it.
    send_item(OP_LOAD, KEY_UNUSED, VALUE_MIN, VALUE_MAX, VALUE_MIN);
    send_item(OP_KEY, KEY_PRESS_DOWN, VALUE_MAX, VALUE_MIN, VALUE_MAX);
    send_item(OP_LOAD, KEY_NONE, '0, VALUE_MIN, VALUE_MAX);
    // Value above the upper bound is pulled down to it on up.
    send_item(OP_KEY, KEY_PRESS_UP, '0, VALUE_MIN, -16'sd5);
    // Value below the lower bound is pushed up to it on down.
    send_item(OP_KEY, KEY_PRESS_DOWN, '0, 16'sd200, VALUE_MAX);
    // Crossed bounds: each direction clamps to its own bound.
    send_item(OP_KEY, KEY_PRESS_UP, '0, 16'sd10, -16'sd10);
    send_item(OP_KEY, KEY_PRESS_DOWN, '0, 16'sd10, -16'sd10);
    send_item(OP_KEY, KEY_PRESS_FWD, '0, VALUE_MIN, VALUE_MAX);
    send_item(OP_KEY, KEY_PRESS_BACK, '0, VALUE_MIN, VALUE_MAX);
    send_item(OP_KEY, KEY_NONE, '0, VALUE_MIN, VALUE_MAX);
    send_item(OP_KEY, KEY_UNUSED, '0, VALUE_MIN, VALUE_MAX);
    // Short hold inside the delay, in both directions, then accept.
    send_item(OP_KEY, KEY_PRESS_UP, '0, VALUE_MIN, VALUE_MAX);
    repeat (3) send_item(OP_KEY, KEY_HOLD_UP, '0, VALUE_MIN, VALUE_MAX);
    repeat (2) send_item(OP_KEY, KEY_HOLD_DOWN, '0, VALUE_MIN, VALUE_MAX);
    send_item(OP_KEY, KEY_PRESS_FWD, '0, VALUE_MIN, VALUE_MAX);
    // All-ones and all-zeros items.
    send_item(OP_LOAD, KEY_UNUSED, -16'sd1, -16'sd1, -16'sd1);
    send_item(OP_KEY, KEY_NONE, '0, '0, '0);

    // No delay and a period of zero: a held key steps every tick.
    set_repeat(0, 0);
    run_random(PHASE_ITEMS);

    // Longest delay, shortest nonzero period; swap the idling shares.
    tx_idle_pct = 60;
    rx_idle_pct = 32;
    set_repeat(255, 1);
    run_random(PHASE_ITEMS);

    set_repeat(3, 255);
    run_random(PHASE_ITEMS);

    // Back-to-back traffic on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_repeat($urandom_range(40), $urandom_range(8, 1));
    run_random(PHASE_ITEMS);

    wait_idle();
    if (mismatches == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/kavu_pkg.sv
src/kavu_repeat.sv
src/kavu_clamp.sv
src/key_autorepeat_value_adjuster_unit.sv
src/kavu_checker.sv
verif/kavu_edit_checker.sv
verif/tb_key_autorepeat_value_adjuster_unit.sv
